>>> src/orlt_pkg.sv
// Shared types, widths and codes for the ordered record table.
package orlt_pkg;

    // Default table depth.
    localparam int CAPACITY_DEF = 16;

    // Field widths of the transfers.
    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int ID_W     = 27;
    localparam int GRADE_W  = 7;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Request payload.
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [POS_W-1:0]   position;
        logic [ID_W-1:0]    student_id;
        logic [GRADE_W-1:0] grade_tenths;
    } in_item_t;

    // Response payload.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    found_index;
        logic [ID_W-1:0]     id_out;
        logic [GRADE_W-1:0]  grade_out;
        logic [COUNT_W-1:0]  count_out;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic pick;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_find;
    } dp_stat_t;

endpackage

>>> src/orlt_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
interface orlt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/orlt_datapath.sv
// Record cells with neighbour shifting, per-cell key compare, lowest-match
// isolation and the response register.
module orlt_datapath #(
    parameter int CAPACITY = orlt_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  orlt_pkg::cmd_t     cmd,
    output orlt_pkg::dp_stat_t stat,
    input  orlt_pkg::in_item_t in_data,
    output orlt_pkg::out_item_t out_data
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > orlt_pkg::POS_W) ? CW : orlt_pkg::POS_W;

    // Latched request.
    logic [orlt_pkg::OP_W-1:0]    op_reg;
    logic [orlt_pkg::POS_W-1:0]   pos_reg;
    logic [orlt_pkg::ID_W-1:0]    key_reg;
    logic [orlt_pkg::GRADE_W-1:0] grade_reg;

    // Table state.
    logic [CW-1:0]                count_reg;
    logic [orlt_pkg::ID_W-1:0]    id_cell_reg [CAPACITY];
    logic [orlt_pkg::GRADE_W-1:0] grade_cell_reg [CAPACITY];

    // Selection vector and status of the operation in flight.
    logic [CAPACITY-1:0]           sel_reg;
    logic [orlt_pkg::STATUS_W-1:0] status_reg;
    orlt_pkg::out_item_t           out_reg;

    logic [CMPW-1:0]               pos_ext;
    logic [CMPW-1:0]               cnt_ext;
    logic [CMPW-1:0]               cap_ext;
    logic                          ins_ok;
    logic                          del_ok;
    logic                          rd_ok;
    logic                          do_insert;
    logic                          do_delete;
    logic [CAPACITY-1:0]           match_vec;
    logic [CAPACITY-1:0]           pos_dec;
    logic [orlt_pkg::ID_W-1:0]     below_id [CAPACITY];
    logic [orlt_pkg::GRADE_W-1:0]  below_grade [CAPACITY];
    logic [orlt_pkg::ID_W-1:0]     above_id [CAPACITY];
    logic [orlt_pkg::GRADE_W-1:0]  above_grade [CAPACITY];
    logic [IW-1:0]                 idx_sel;
    logic [orlt_pkg::ID_W-1:0]     id_sel;
    logic [orlt_pkg::GRADE_W-1:0]  grade_sel;

    // Latch the request on its transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_data.operation;
            pos_reg   <= in_data.position;
            key_reg   <= in_data.student_id;
            grade_reg <= in_data.grade_tenths;
        end
    end

    // Range checks against the fill count.
    assign pos_ext   = CMPW'(pos_reg);
    assign cnt_ext   = CMPW'(count_reg);
    assign cap_ext   = CMPW'(CAPACITY);
    assign ins_ok    = (cnt_ext < cap_ext) && (pos_ext <= cnt_ext);
    assign del_ok    = pos_ext < cnt_ext;
    assign rd_ok     = pos_ext < cnt_ext;
    assign do_insert = (op_reg == orlt_pkg::OP_INSERT) && ins_ok;
    assign do_delete = (op_reg == orlt_pkg::OP_DELETE) && del_ok;
    assign pos_dec   = CAPACITY'(1) << pos_reg;

    assign stat.is_find = (op_reg == orlt_pkg::OP_FIND);

    // One cell per entry: it loads the key, its lower or its upper neighbour.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMPW-1:0] I_EXT = CMPW'(i);

        if (i == 0)
        begin : g_first
            assign below_id[i]    = key_reg;
            assign below_grade[i] = grade_reg;
        end
        else
        begin : g_inner_lo
            assign below_id[i]    = id_cell_reg[i-1];
            assign below_grade[i] = grade_cell_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign above_id[i]    = id_cell_reg[i];
            assign above_grade[i] = grade_cell_reg[i];
        end
        else
        begin : g_inner_hi
            assign above_id[i]    = id_cell_reg[i+1];
            assign above_grade[i] = grade_cell_reg[i+1];
        end

        // Per-cell key compare, limited to filled entries.
        assign match_vec[i] = (id_cell_reg[i] == key_reg) && (I_EXT < cnt_ext);

        always_ff @(posedge clk)
        begin
            if (cmd.eval && do_insert)
            begin
                if (I_EXT == pos_ext)
                begin
                    id_cell_reg[i]    <= key_reg;
                    grade_cell_reg[i] <= grade_reg;
                end
                else if (I_EXT > pos_ext)
                begin
                    id_cell_reg[i]    <= below_id[i];
                    grade_cell_reg[i] <= below_grade[i];
                end
            end
            else if (cmd.eval && do_delete)
            begin
                if (I_EXT >= pos_ext)
                begin
                    id_cell_reg[i]    <= above_id[i];
                    grade_cell_reg[i] <= above_grade[i];
                end
            end
        end
    end

    // Fill count, status and selection vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sel_reg    <= '0;
            status_reg <= orlt_pkg::ST_OK;
        end
        else if (cmd.eval)
        begin
            if (do_insert)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_delete)
            begin
                count_reg <= count_reg - CW'(1);
            end

            case (op_reg)
                orlt_pkg::OP_INSERT:
                begin
                    status_reg <= ins_ok ? orlt_pkg::ST_OK : orlt_pkg::ST_BAD;
                    sel_reg    <= '0;
                end
                orlt_pkg::OP_DELETE:
                begin
                    status_reg <= del_ok ? orlt_pkg::ST_OK : orlt_pkg::ST_BAD;
                    sel_reg    <= '0;
                end
                orlt_pkg::OP_FIND:
                begin
                    status_reg <= orlt_pkg::ST_MISSING;
                    sel_reg    <= match_vec;
                end
                orlt_pkg::OP_READ:
                begin
                    status_reg <= rd_ok ? orlt_pkg::ST_OK : orlt_pkg::ST_BAD;
                    sel_reg    <= rd_ok ? pos_dec : '0;
                end
                default:
                begin
                    status_reg <= orlt_pkg::ST_BAD;
                    sel_reg    <= '0;
                end
            endcase
        end
        else if (cmd.pick)
        begin
            // Keep only the lowest matching entry.
            sel_reg    <= sel_reg & (~sel_reg + CAPACITY'(1));
            status_reg <= (|sel_reg) ? orlt_pkg::ST_OK : orlt_pkg::ST_MISSING;
        end
    end

    // One-hot selection of the reported entry; all zero when nothing is chosen.
    always_comb
    begin
        idx_sel   = '0;
        id_sel    = '0;
        grade_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_reg[i])
            begin
                idx_sel   = idx_sel | IW'(i);
                id_sel    = id_sel | id_cell_reg[i];
                grade_sel = grade_sel | grade_cell_reg[i];
            end
        end
    end

    // Response register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.status      <= status_reg;
            out_reg.found_index <= orlt_pkg::IDX_W'(idx_sel);
            out_reg.id_out      <= id_sel;
            out_reg.grade_out   <= grade_sel;
            out_reg.count_out   <= orlt_pkg::COUNT_W'(count_reg);
        end
    end

    assign out_data = out_reg;

`ifndef SYNTH
    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAPACITY)
        else $error("fill count above capacity");

    // At most one entry is reported.
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> $onehot0(sel_reg))
        else $error("more than one entry selected");

    // A rejected or unmatched operation reports no entry.
    a_sel_clear_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && (status_reg != orlt_pkg::ST_OK)) |-> (sel_reg == '0))
        else $error("entry selected on error status");
`endif

endmodule

>>> src/orlt_ctrl.sv
// Sequencer: capture, evaluate, lowest-match pick for find, response load.
module orlt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  orlt_pkg::dp_stat_t stat,
    output orlt_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_SEL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state, commands and response valid.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = (state_reg == S_IDLE);
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.is_find ? S_PICK : S_SEL;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                // Load only once the previous response has gone.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and response valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // A request transfer always starts evaluation.
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EVAL))
        else $error("request transfer not followed by evaluation");

    // The response register is never overwritten while it still holds a result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("response overwritten before transfer");

    // A new response appears only after the select step.
    a_valid_from_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_SEL))
        else $error("response valid raised outside select step");
`endif

endmodule

>>> src/ordered_record_list_table.sv
// Sequence: after the request transfer the evaluate step runs, then for find the
// lowest-match pick, then the select step that loads the response register once
// the previous response has gone. A request is taken only in idle, after the last
// one is loaded; the next request is taken while the previous response waits.
// Reset: asynchronous, active low; clears the fill count and the control
// state. Record contents are not cleared and are only read below the count.
module ordered_record_list_table #(
    parameter int CAPACITY = orlt_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    orlt_stream_if.sink          req,
    orlt_stream_if.source        rsp
);

    orlt_pkg::cmd_t      cmd;
    orlt_pkg::dp_stat_t  stat;
    orlt_pkg::out_item_t rsp_data;
    logic                req_ready;
    logic                rsp_valid;

    // Sequencer.
    orlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req_ready),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Record cells and response register.
    orlt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (req.data),
        .out_data (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

endmodule

>>> dv/ordered_record_list_table_tb.sv
module ordered_record_list_table_tb;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PRINT_LIMIT   = 40;
    localparam int POOL_SIZE     = 8;
    localparam logic [orlt_pkg::ID_W-1:0] ID_TOP  = 27'd99999999;
    localparam logic [orlt_pkg::ID_W-1:0] ID_ALL1 = '1;

    // Predicts the table contents and the result of every accepted request.
    class record_table_predictor;
        logic [orlt_pkg::ID_W-1:0]    ids [orlt_pkg::CAPACITY_DEF];
        logic [orlt_pkg::GRADE_W-1:0] grades [orlt_pkg::CAPACITY_DEF];
        int                           fill;
        orlt_pkg::out_item_t          expected_results [$];
        int unsigned                  mismatch_count;

        function new();
            fill = 0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Applies one accepted request to the table and queues its result.
        function void note_request(input orlt_pkg::in_item_t rq);
            orlt_pkg::out_item_t r;
            int                  i;
            bit                  hit;
            r = '0;
            r.status = orlt_pkg::ST_OK;
            hit = 1'b0;
            case (rq.operation)
                orlt_pkg::OP_INSERT:
                begin
                    if (fill >= orlt_pkg::CAPACITY_DEF || rq.position > fill)
                        r.status = orlt_pkg::ST_BAD;
                    else
                    begin
                        for (i = fill; i > rq.position; i--)
                        begin
                            ids[i]    = ids[i - 1];
                            grades[i] = grades[i - 1];
                        end
                        ids[rq.position]    = rq.student_id;
                        grades[rq.position] = rq.grade_tenths;
                        fill++;
                    end
                end
                orlt_pkg::OP_DELETE:
                begin
                    if (rq.position >= fill)
                        r.status = orlt_pkg::ST_BAD;
                    else
                    begin
                        for (i = rq.position; i + 1 < fill; i++)
                        begin
                            ids[i]    = ids[i + 1];
                            grades[i] = grades[i + 1];
                        end
                        fill--;
                    end
                end
                orlt_pkg::OP_FIND:
                begin
                    // The lowest matching position wins.
                    r.status = orlt_pkg::ST_MISSING;
                    for (i = 0; i < fill; i++)
                    begin
                        if (!hit && ids[i] == rq.student_id)
                        begin
                            hit = 1'b1;
                            r.status      = orlt_pkg::ST_OK;
                            r.found_index = orlt_pkg::IDX_W'(i);
                            r.id_out      = ids[i];
                            r.grade_out   = grades[i];
                        end
                    end
                end
                default:
                begin
                    if (rq.position >= fill)
                        r.status = orlt_pkg::ST_BAD;
                    else
                    begin
                        r.found_index = rq.position[orlt_pkg::IDX_W-1:0];
                        r.id_out      = ids[rq.position];
                        r.grade_out   = grades[rq.position];
                    end
                end
            endcase
            r.count_out = orlt_pkg::COUNT_W'(fill);
            expected_results.push_back(r);
        endfunction

        task report(input string what);
            if (mismatch_count < PRINT_LIMIT)
                $display("mismatch at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        // Compares one accepted result with the oldest prediction.
        task check_response(input orlt_pkg::out_item_t got);
            orlt_pkg::out_item_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.found_index !== want.found_index)
                report($sformatf("found_index %0d, expected %0d",
                                 got.found_index, want.found_index));
            if (got.id_out !== want.id_out)
                report($sformatf("id_out %0d, expected %0d", got.id_out, want.id_out));
            if (got.grade_out !== want.grade_out)
                report($sformatf("grade_out %0d, expected %0d",
                                 got.grade_out, want.grade_out));
            if (got.count_out !== want.count_out)
                report($sformatf("count_out %0d, expected %0d",
                                 got.count_out, want.count_out));
        endtask
    endclass

    logic clk;
    logic rst_n;

    orlt_stream_if #(.T(orlt_pkg::in_item_t))  req_if ();
    orlt_stream_if #(.T(orlt_pkg::out_item_t)) rsp_if ();

    ordered_record_list_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    record_table_predictor table_pred = new();

    bit                          steady;
    bit                          hold_off_req;
    bit                          grow;
    int unsigned                 burst_left;
    int unsigned                 quiet_cycles;
    logic [orlt_pkg::ID_W-1:0]   id_pool [POOL_SIZE];

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic orlt_pkg::in_item_t make_request(
        input logic [orlt_pkg::OP_W-1:0] op, input int pos,
        input logic [orlt_pkg::ID_W-1:0] id, input int grade);
        orlt_pkg::in_item_t rq;
        rq.operation    = op;
        rq.position     = orlt_pkg::POS_W'(pos);
        rq.student_id   = id;
        rq.grade_tenths = orlt_pkg::GRADE_W'(grade);
        return rq;
    endfunction

    function automatic logic [orlt_pkg::ID_W-1:0] random_id();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 30)
            return id_pool[$urandom_range(POOL_SIZE - 1, 0)];
        if (roll < 90)
            return orlt_pkg::ID_W'($urandom_range(99999999, 0));
        return orlt_pkg::ID_W'($urandom);
    endfunction

    // Mostly well-formed requests against the current fill, with some out of range.
    function automatic orlt_pkg::in_item_t random_request();
        orlt_pkg::in_item_t rq;
        int unsigned        roll;
        int                 fill;
        fill = table_pred.fill;
        if (fill == orlt_pkg::CAPACITY_DEF && $urandom_range(3, 0) == 0)
            grow = 1'b0;
        else if (fill == 0 && $urandom_range(3, 0) == 0)
            grow = 1'b1;
        else if ($urandom_range(99, 0) == 0)
            grow = !grow;
        roll = $urandom_range(99, 0);
        if (roll < (grow ? 45 : 20))
            rq.operation = orlt_pkg::OP_INSERT;
        else if (roll < 65)
            rq.operation = orlt_pkg::OP_DELETE;
        else if (roll < 85)
            rq.operation = orlt_pkg::OP_FIND;
        else
            rq.operation = orlt_pkg::OP_READ;
        if ($urandom_range(99, 0) < 15)
            rq.position = orlt_pkg::POS_W'($urandom_range(31, 0));
        else if (rq.operation == orlt_pkg::OP_INSERT)
            rq.position = orlt_pkg::POS_W'($urandom_range(fill, 0));
        else
            rq.position = (fill == 0) ? '0 : orlt_pkg::POS_W'($urandom_range(fill - 1, 0));
        if (rq.operation == orlt_pkg::OP_FIND && fill > 0 && $urandom_range(99, 0) < 60)
            rq.student_id = table_pred.ids[$urandom_range(fill - 1, 0)];
        else
            rq.student_id = random_id();
        if ($urandom_range(9, 0) == 0)
            rq.grade_tenths = orlt_pkg::GRADE_W'($urandom_range(127, 0));
        else
            rq.grade_tenths = orlt_pkg::GRADE_W'($urandom_range(100, 0));
        return rq;
    endfunction

    // Offers one request and returns at the edge where its transfer happens.
    task automatic send_request(input orlt_pkg::in_item_t rq);
        int unsigned n;
        n = (steady || burst_left != 0) ? 0 : gap_len();
        if (burst_left != 0)
            burst_left--;
        if (n != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= rq;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        table_pred.note_request(rq);
    endtask

    // Receiver pacing, including one long hold-off on request.
    initial
    begin : rx_pacing
        int unsigned n;
        rsp_if.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
            begin
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                n = gap_len();
                if (n != 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checking and the watchdog on stalled transfers.
    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
            table_pred.check_response(rsp_if.data);
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int k;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        grow         = 1'b1;
        burst_left   = 0;
        quiet_cycles = 0;
        id_pool[0] = '0;
        id_pool[1] = ID_TOP;
        id_pool[2] = ID_ALL1;
        for (k = 3; k < POOL_SIZE; k++)
            id_pool[k] = orlt_pkg::ID_W'($urandom_range(99999999, 0));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, bounds, duplicates and the full table.
        send_request(make_request(orlt_pkg::OP_READ, 0, '0, 0));
        send_request(make_request(orlt_pkg::OP_DELETE, 0, '0, 0));
        send_request(make_request(orlt_pkg::OP_FIND, 0, 27'd5, 0));
        send_request(make_request(orlt_pkg::OP_INSERT, 1, 27'd7, 3));
        send_request(make_request(orlt_pkg::OP_INSERT, 0, ID_ALL1, 127));
        send_request(make_request(orlt_pkg::OP_INSERT, 0, '0, 0));
        send_request(make_request(orlt_pkg::OP_INSERT, 2, ID_TOP, 100));
        send_request(make_request(orlt_pkg::OP_INSERT, 1, '0, 55));
        send_request(make_request(orlt_pkg::OP_FIND, 0, '0, 0));
        send_request(make_request(orlt_pkg::OP_FIND, 0, ID_TOP, 0));
        send_request(make_request(orlt_pkg::OP_FIND, 0, 27'd12345, 0));
        send_request(make_request(orlt_pkg::OP_READ, 3, '0, 0));
        send_request(make_request(orlt_pkg::OP_READ, 4, '0, 0));
        send_request(make_request(orlt_pkg::OP_READ, 31, '0, 0));
        send_request(make_request(orlt_pkg::OP_DELETE, 31, '0, 0));
        send_request(make_request(orlt_pkg::OP_INSERT, 31, 27'd9, 9));
        send_request(make_request(orlt_pkg::OP_DELETE, 0, '0, 0));
        send_request(make_request(orlt_pkg::OP_FIND, 0, '0, 0));
        while (table_pred.fill < orlt_pkg::CAPACITY_DEF)
            send_request(make_request(orlt_pkg::OP_INSERT,
                                      $urandom_range(table_pred.fill, 0),
                                      random_id(), $urandom_range(100, 0)));
        send_request(make_request(orlt_pkg::OP_INSERT, 0, 27'd1, 1));
        send_request(make_request(orlt_pkg::OP_INSERT, orlt_pkg::CAPACITY_DEF, 27'd1, 1));
        send_request(make_request(orlt_pkg::OP_READ, orlt_pkg::CAPACITY_DEF - 1, '0, 0));
        send_request(make_request(orlt_pkg::OP_READ, orlt_pkg::CAPACITY_DEF, '0, 0));
        send_request(make_request(orlt_pkg::OP_DELETE, orlt_pkg::CAPACITY_DEF - 1, '0, 0));
        send_request(make_request(orlt_pkg::OP_DELETE, 0, '0, 0));
        send_request(make_request(orlt_pkg::OP_FIND, 0, 27'd4242, 0));

        // Random part, with a receiver hold-off, a full drain and a stretch without idling.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 200)
            begin
                hold_off_req = 1'b1;
                burst_left   = 60;
            end
            if (k == 700)
            begin
                // Withdraw the offer so the last request is not taken twice.
                req_if.valid <= 1'b0;
                while (table_pred.pending() != 0)
                    @(posedge clk);
            end
            if (k == 1000)
                steady = 1'b1;
            if (k == 1200)
                steady = 1'b0;
            send_request(random_request());
        end
        req_if.valid <= 1'b0;

        // Wait for the last results, then run on for DRAIN_CYCLES to catch strays.
        while (table_pred.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_pred.mismatch_count == 0 && table_pred.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
